>>> rtl/edns_pkg.sv
`default_nettype none
package edns_pkg;

  localparam int HDR_LEN    = 11;
  localparam int OUTQ_DEPTH = 4;

  localparam logic [7:0]  OPT_TYPE     = 8'd41;
  localparam logic [15:0] CODE_SUBNET  = 16'd8;
  localparam logic [15:0] CODE_KEYTAG  = 16'd14;
  localparam logic [15:0] CODE_UNASSGN = 16'd65000;
  localparam logic [15:0] CODE_EXP_KNW = 16'd65001;
  localparam logic [15:0] CODE_FUTURE  = 16'd65535;

  localparam logic [15:0] TAG_A_RST = 16'h4a5c;
  localparam logic [15:0] TAG_B_RST = 16'h4f66;
  localparam logic [15:0] TAG_C_RST = 16'h9728;

  typedef enum logic [1:0] {
    CFG_TAG_A = 2'd0,
    CFG_TAG_B = 2'd1,
    CFG_TAG_C = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD = 2'd0,
    ST_HDR  = 2'd1,
    ST_MALF = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_KNOWN  = 2'd0,
    CLS_UNASSN = 2'd1,
    CLS_EXPER  = 2'd2,
    CLS_FUTURE = 2'd3
  } class_t;

  typedef struct packed {
    logic        is_summary;
    logic [15:0] option_code;
    logic [15:0] option_length;
    logic [1:0]  option_class;
    logic [3:0]  keytag_hits;
    logic [15:0] subnet_family;
    logic [7:0]  subnet_prefix;
    logic [14:0] seen_mask;
    logic [15:0] udp_size;
    logic        do_flag;
    logic [7:0]  edns_version;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic rec_vld;
    logic sum_vld;
    res_t rec;
    res_t sum;
  } push_t;

  function automatic class_t class_of(input logic [15:0] c);
    class_t cls;
    if (c <= 16'd3 || (c >= 16'd5 && c <= 16'd14) || c == CODE_EXP_KNW) begin
      cls = CLS_KNOWN;
    end else if (c == CODE_FUTURE) begin
      cls = CLS_FUTURE;
    end else if (c <= CODE_UNASSGN) begin
      cls = CLS_UNASSN;
    end else begin
      cls = CLS_EXPER;
    end
    return cls;
  endfunction

  function automatic logic [14:0] seen_bit(input logic [15:0] c);
    logic [14:0] m;
    m = '0;
    if (c <= 16'd3) begin
      m[c[1:0]] = 1'b1;
    end else if (c >= 16'd5 && c <= 16'd14) begin
      m[4'(c[3:0] - 4'd1)] = 1'b1;
    end else if (c == CODE_EXP_KNW) begin
      m[14] = 1'b1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/edns_in_if.sv
`default_nettype none
interface edns_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/edns_out_if.sv
`default_nettype none
interface edns_out_if;
  logic        valid;
  logic        ready;
  logic        is_summary;
  logic [15:0] option_code;
  logic [15:0] option_length;
  logic [1:0]  option_class;
  logic [3:0]  keytag_hits;
  logic [15:0] subnet_family;
  logic [7:0]  subnet_prefix;
  logic [14:0] seen_mask;
  logic [15:0] udp_size;
  logic        do_flag;
  logic [7:0]  edns_version;
  logic [1:0]  status;

  modport source (
    output valid, output is_summary, output option_code, output option_length,
    output option_class, output keytag_hits, output subnet_family,
    output subnet_prefix, output seen_mask, output udp_size, output do_flag,
    output edns_version, output status, input ready
  );
  modport sink (
    input valid, input is_summary, input option_code, input option_length,
    input option_class, input keytag_hits, input subnet_family,
    input subnet_prefix, input seen_mask, input udp_size, input do_flag,
    input edns_version, input status, output ready
  );
endinterface
`default_nettype wire

>>> rtl/edns_cfg_if.sv
`default_nettype none
interface edns_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/edns_parse.sv
`default_nettype none
module edns_parse import edns_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [15:0] cfg_data,
  output push_t            push
);

  logic [15:0] tag_a_r, tag_b_r, tag_c_r;

  logic [3:0]  hdr_pos_r, hdr_pos_nxt;
  logic [15:0] pay_r, pay_nxt;
  logic        do_r, do_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [15:0] rem_r, rem_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] code_r, code_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] fam_r, fam_nxt;
  logic [7:0]  pfx_r, pfx_nxt;
  logic [7:0]  thi_r, thi_nxt;
  logic [3:0]  hits_r, hits_nxt;
  logic [14:0] seen_r, seen_nxt;
  status_t     err_r, err_nxt;

  logic        emit;
  logic [15:0] idx;
  logic [15:0] tag_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= TAG_A_RST;
      tag_b_r <= TAG_B_RST;
      tag_c_r <= TAG_C_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TAG_A: tag_a_r <= cfg_data;
        CFG_TAG_B: tag_b_r <= cfg_data;
        CFG_TAG_C: tag_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    pay_nxt     = pay_r;
    do_nxt      = do_r;
    ver_nxt     = ver_r;
    rem_nxt     = rem_r;
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    code_nxt    = code_r;
    len_nxt     = len_r;
    fam_nxt     = fam_r;
    pfx_nxt     = pfx_r;
    thi_nxt     = thi_r;
    hits_nxt    = hits_r;
    seen_nxt    = seen_r;
    err_nxt     = err_r;
    emit        = 1'b0;
    idx         = '0;
    tag_word    = {thi_r, data_byte};
    push        = '0;

    if (acc) begin
      if (err_r != ST_HDR) begin
        if (hdr_pos_r < 4'(HDR_LEN)) begin
          case (hdr_pos_r)
            4'd0, 4'd1: if (data_byte != 8'd0) err_nxt = ST_HDR;
            4'd2:  if (data_byte != OPT_TYPE) err_nxt = ST_HDR;
            4'd3:  pay_nxt = {data_byte, 8'd0};
            4'd4:  pay_nxt = {pay_r[15:8], data_byte};
            4'd6:  ver_nxt = data_byte;
            4'd7:  do_nxt = data_byte[7];
            4'd9:  rem_nxt = {data_byte, 8'd0};
            4'd10: rem_nxt = {rem_r[15:8], data_byte};
            default: ;
          endcase
          hdr_pos_nxt = hdr_pos_r + 4'd1;
        end else if (rem_r != 16'd0) begin
          rem_nxt = rem_r - 16'd1;
          if (phase_r == PH_CODE || phase_r == PH_LEN) begin
            if (left_r == 16'd0) begin
              if (phase_r == PH_CODE) code_nxt = {data_byte, 8'd0};
              else len_nxt = {data_byte, 8'd0};
              left_nxt = 16'd1;
            end else if (phase_r == PH_CODE) begin
              code_nxt  = code_r | {8'd0, data_byte};
              left_nxt  = '0;
              phase_nxt = PH_LEN;
            end else begin
              len_nxt   = len_r | {8'd0, data_byte};
              phase_nxt = PH_BODY;
              left_nxt  = len_nxt;
              fam_nxt   = '0;
              pfx_nxt   = '0;
              thi_nxt   = '0;
              hits_nxt  = '0;
              if (len_nxt == 16'd0) begin
                emit      = 1'b1;
                phase_nxt = PH_CODE;
                left_nxt  = '0;
              end
            end
          end else begin
            idx = len_r - left_r;
            if (code_r == CODE_SUBNET) begin
              if (idx == 16'd0) fam_nxt = {data_byte, fam_r[7:0]};
              else if (idx == 16'd1) fam_nxt = {fam_r[15:8], data_byte};
              else if (idx == 16'd2) pfx_nxt = data_byte;
            end else if (code_r == CODE_KEYTAG) begin
              if (!idx[0]) thi_nxt = data_byte;
              else if (tag_word == tag_a_r) hits_nxt = hits_r | 4'b0001;
              else if (tag_word == tag_b_r) hits_nxt = hits_r | 4'b0010;
              else if (tag_word == tag_c_r) hits_nxt = hits_r | 4'b0100;
              else hits_nxt = hits_r | 4'b1000;
            end
            left_nxt = left_r - 16'd1;
            if (left_nxt == 16'd0) begin
              emit      = 1'b1;
              phase_nxt = PH_CODE;
            end
          end
          if (rem_nxt == 16'd0 && !emit) begin
            if (phase_nxt == PH_BODY) begin
              if (err_nxt == ST_GOOD) err_nxt = ST_MALF;
              emit      = 1'b1;
              phase_nxt = PH_CODE;
              left_nxt  = '0;
            end else if (left_nxt != 16'd0 || phase_nxt == PH_LEN) begin
              if (err_nxt == ST_GOOD) err_nxt = ST_MALF;
            end
          end
        end
      end

      if (last_byte && err_nxt != ST_HDR) begin
        if (hdr_pos_nxt < 4'(HDR_LEN)) begin
          err_nxt = ST_HDR;
        end else if (rem_nxt != 16'd0) begin
          if (err_nxt == ST_GOOD) err_nxt = ST_MALF;
          if (phase_nxt == PH_BODY && !emit) begin
            emit      = 1'b1;
            phase_nxt = PH_CODE;
            left_nxt  = '0;
          end
        end
      end

      if (emit) begin
        seen_nxt                = seen_nxt | seen_bit(code_nxt);
        push.rec_vld            = 1'b1;
        push.rec.option_code    = code_nxt;
        push.rec.option_length  = len_nxt;
        push.rec.option_class   = class_of(code_nxt);
        push.rec.keytag_hits    = (code_nxt == CODE_KEYTAG) ? hits_nxt : 4'd0;
        push.rec.subnet_family  = (code_nxt == CODE_SUBNET) ? fam_nxt : 16'd0;
        push.rec.subnet_prefix  = (code_nxt == CODE_SUBNET) ? pfx_nxt : 8'd0;
      end

      if (last_byte) begin
        push.sum_vld          = 1'b1;
        push.sum.is_summary   = 1'b1;
        push.sum.seen_mask    = seen_nxt;
        push.sum.udp_size     = pay_nxt;
        push.sum.do_flag      = do_nxt;
        push.sum.edns_version = ver_nxt;
        push.sum.status       = err_nxt;
        hdr_pos_nxt = '0;
        pay_nxt     = '0;
        do_nxt      = 1'b0;
        ver_nxt     = '0;
        rem_nxt     = '0;
        phase_nxt   = PH_CODE;
        left_nxt    = '0;
        code_nxt    = '0;
        len_nxt     = '0;
        fam_nxt     = '0;
        pfx_nxt     = '0;
        thi_nxt     = '0;
        hits_nxt    = '0;
        seen_nxt    = '0;
        err_nxt     = ST_GOOD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r <= '0;
      pay_r     <= '0;
      do_r      <= 1'b0;
      ver_r     <= '0;
      rem_r     <= '0;
      phase_r   <= PH_CODE;
      left_r    <= '0;
      code_r    <= '0;
      len_r     <= '0;
      fam_r     <= '0;
      pfx_r     <= '0;
      thi_r     <= '0;
      hits_r    <= '0;
      seen_r    <= '0;
      err_r     <= ST_GOOD;
    end else begin
      hdr_pos_r <= hdr_pos_nxt;
      pay_r     <= pay_nxt;
      do_r      <= do_nxt;
      ver_r     <= ver_nxt;
      rem_r     <= rem_nxt;
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      code_r    <= code_nxt;
      len_r     <= len_nxt;
      fam_r     <= fam_nxt;
      pfx_r     <= pfx_nxt;
      thi_r     <= thi_nxt;
      hits_r    <= hits_nxt;
      seen_r    <= seen_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/edns_outq.sv
`default_nettype none
module edns_outq import edns_pkg::*; #(
  parameter int QUEUE_DEPTH = OUTQ_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  res_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp1, wp2;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_push;
  logic          pop;
  res_t          first;

  assign out_valid = cnt_r != '0;
  assign room      = cnt_r <= CW'(QUEUE_DEPTH - 2);
  assign pop       = out_valid && out_ready;
  assign out_res   = mem_r[rp_r];
  assign first     = push.rec_vld ? push.rec : push.sum;
  assign n_push    = CW'(push.rec_vld) + CW'(push.sum_vld);

  assign wp1 = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign wp2 = (wp1 == PW'(QUEUE_DEPTH - 1)) ? '0 : wp1 + 1'b1;

  always_comb begin
    wp_nxt = wp_r;
    if (push.rec_vld && push.sum_vld) wp_nxt = wp2;
    else if (push.rec_vld || push.sum_vld) wp_nxt = wp1;
    rp_nxt = rp_r;
    if (pop) rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + n_push - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.rec_vld || push.sum_vld) mem_r[wp_r] <= first;
    if (push.rec_vld && push.sum_vld) mem_r[wp1] <= push.sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dns_edns_option_parser.sv
`default_nettype none
// EDNS0 OPT record parser. Takes one record byte per cycle on in_ch (last_byte
// marks the end of the packet) and returns on out_ch one request per finished
// option plus one summary request on the last byte. Each byte is handled in
// the cycle it is accepted; results go into a small result queue
// (QUEUE_DEPTH entries, default 4) and in_ch.ready is high while the queue has
// room for two results, so bytes stream at one per cycle as long as out_ch
// drains. A byte that both closes an option and ends the packet yields two
// results. Watched key tags go in on cfg_ch (index 0, 1, 2); the user writes
// them only while the block is idle, unenforced. cfg_ch.ready is always high.
module dns_edns_option_parser import edns_pkg::*; #(
  parameter int QUEUE_DEPTH = OUTQ_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  edns_in_if.sink    in_ch,
  edns_out_if.source out_ch,
  edns_cfg_if.sink   cfg_ch
);

  logic  acc;
  logic  room;
  push_t push;
  res_t  res;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = room;
  assign acc          = in_ch.valid && room;

  edns_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .push      (push)
  );

  edns_outq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.is_summary    = res.is_summary;
  assign out_ch.option_code   = res.option_code;
  assign out_ch.option_length = res.option_length;
  assign out_ch.option_class  = res.option_class;
  assign out_ch.keytag_hits   = res.keytag_hits;
  assign out_ch.subnet_family = res.subnet_family;
  assign out_ch.subnet_prefix = res.subnet_prefix;
  assign out_ch.seen_mask     = res.seen_mask;
  assign out_ch.udp_size      = res.udp_size;
  assign out_ch.do_flag       = res.do_flag;
  assign out_ch.edns_version  = res.edns_version;
  assign out_ch.status        = res.status;

endmodule
`default_nettype wire

>>> verif/dns_edns_option_parser_test.sv
`default_nettype none
module dns_edns_option_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import edns_pkg::*;

  class opt_record_board;
    logic [15:0] tag_a, tag_b, tag_c;
    int unsigned hdr_pos;
    logic [15:0] udp, rd_left, opt_left, code, length, family;
    logic        dok;
    logic [7:0]  ver, prefix, tag_hi;
    logic [3:0]  hits;
    logic [14:0] seen;
    phase_t      phase;
    status_t     stat;
    res_t        due[$];
    int          errors;

    function new();
      tag_a = TAG_A_RST;
      tag_b = TAG_B_RST;
      tag_c = TAG_C_RST;
      errors = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      hdr_pos = 0; udp = '0; dok = 1'b0; ver = '0; rd_left = '0;
      phase = PH_CODE; opt_left = '0; code = '0; length = '0; family = '0;
      prefix = '0; tag_hi = '0; hits = '0; seen = '0; stat = ST_GOOD;
    endfunction

    function void set_tag(logic [1:0] idx, logic [15:0] v);
      case (idx)
        CFG_TAG_A: tag_a = v;
        CFG_TAG_B: tag_b = v;
        CFG_TAG_C: tag_c = v;
        default: ;
      endcase
    endfunction

    function void note_malformed();
      if (stat == ST_GOOD) stat = ST_MALF;
    endfunction

    function void finish_option();
      res_t   r;
      class_t cls;
      int     seen_idx;
      seen_idx = -1;
      if (code <= 16'd3) begin
        cls = CLS_KNOWN;
        seen_idx = int'(code);
      end else if (code >= 16'd5 && code <= 16'd14) begin
        cls = CLS_KNOWN;
        seen_idx = int'(code) - 1;
      end else if (code == CODE_EXP_KNW) begin
        cls = CLS_KNOWN;
        seen_idx = 14;
      end else if (code == CODE_FUTURE) begin
        cls = CLS_FUTURE;
      end else if (code <= CODE_UNASSGN) begin
        cls = CLS_UNASSN;
      end else begin
        cls = CLS_EXPER;
      end
      if (seen_idx >= 0) seen[seen_idx] = 1'b1;
      r = '0;
      r.option_code = code;
      r.option_length = length;
      r.option_class = cls;
      if (code == CODE_KEYTAG) r.keytag_hits = hits;
      if (code == CODE_SUBNET) begin
        r.subnet_family = family;
        r.subnet_prefix = prefix;
      end
      due.push_back(r);
      phase = PH_CODE;
      opt_left = '0;
    endfunction

    function void match_tag(logic [15:0] t);
      if (t == tag_a) hits[0] = 1'b1;
      else if (t == tag_b) hits[1] = 1'b1;
      else if (t == tag_c) hits[2] = 1'b1;
      else hits[3] = 1'b1;
    endfunction

    function bit rdata_byte(logic [7:0] b);
      bit          done;
      logic [15:0] idx;
      done = 1'b0;
      rd_left = rd_left - 16'd1;
      if (phase != PH_BODY) begin
        if (opt_left == 0) begin
          if (phase == PH_CODE) code = {b, 8'h00};
          else length = {b, 8'h00};
          opt_left = 16'd1;
        end else begin
          opt_left = '0;
          if (phase == PH_CODE) begin
            code[7:0] = b;
            phase = PH_LEN;
          end else begin
            length[7:0] = b;
            phase = PH_BODY;
            opt_left = length;
            family = '0; prefix = '0; tag_hi = '0; hits = '0;
            if (length == 0) begin
              finish_option();
              done = 1'b1;
            end
          end
        end
      end else begin
        idx = length - opt_left;
        if (code == CODE_SUBNET) begin
          if (idx == 0) family[15:8] = b;
          else if (idx == 1) family[7:0] = b;
          else if (idx == 2) prefix = b;
        end else if (code == CODE_KEYTAG) begin
          if (!idx[0]) tag_hi = b;
          else match_tag({tag_hi, b});
        end
        opt_left = opt_left - 16'd1;
        if (opt_left == 0) begin
          finish_option();
          done = 1'b1;
        end
      end
      if (rd_left == 0 && !done) begin
        if (phase == PH_BODY) begin
          note_malformed();
          finish_option();
          done = 1'b1;
        end else if (opt_left != 0 || phase == PH_LEN) begin
          note_malformed();
        end
      end
      return done;
    endfunction

    function void header_byte(logic [7:0] b);
      case (hdr_pos)
        0, 1: if (b != 8'd0) stat = ST_HDR;
        2: if (b != OPT_TYPE) stat = ST_HDR;
        3: udp = {b, 8'h00};
        4: udp[7:0] = b;
        6: ver = b;
        7: dok = b[7];
        9: rd_left = {b, 8'h00};
        10: rd_left[7:0] = b;
        default: ;
      endcase
      hdr_pos++;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      bit   done;
      res_t s;
      done = 1'b0;
      if (stat != ST_HDR) begin
        if (hdr_pos < HDR_LEN) header_byte(b);
        else if (rd_left != 0) done = rdata_byte(b);
      end
      if (last) begin
        if (stat != ST_HDR) begin
          if (hdr_pos < HDR_LEN) begin
            stat = ST_HDR;
          end else if (rd_left != 0) begin
            note_malformed();
            if (phase == PH_BODY && !done) finish_option();
          end
        end
        s = '0;
        s.is_summary = 1'b1;
        s.seen_mask = seen;
        s.udp_size = udp;
        s.do_flag = dok;
        s.edns_version = ver;
        s.status = stat;
        due.push_back(s);
        clear_packet();
      end
    endfunction

    function void note_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_record(res_t got);
      res_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = due.pop_front();
      note_field("is_summary", want.is_summary, got.is_summary);
      note_field("option_code", want.option_code, got.option_code);
      note_field("option_length", want.option_length, got.option_length);
      note_field("option_class", want.option_class, got.option_class);
      note_field("keytag_hits", want.keytag_hits, got.keytag_hits);
      note_field("subnet_family", want.subnet_family, got.subnet_family);
      note_field("subnet_prefix", want.subnet_prefix, got.subnet_prefix);
      note_field("seen_mask", want.seen_mask, got.seen_mask);
      note_field("udp_size", want.udp_size, got.udp_size);
      note_field("do_flag", want.do_flag, got.do_flag);
      note_field("edns_version", want.edns_version, got.edns_version);
      note_field("status", want.status, got.status);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  edns_in_if  in_ch();
  edns_out_if out_ch();
  edns_cfg_if cfg_ch();

  dns_edns_option_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  opt_record_board board;
  logic [7:0]  pkt[$];
  logic [7:0]  opt_body[$];
  logic [15:0] tags_now[3];
  int          burst_left;
  int          bytes_sent;
  bit          hold_request;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) board.set_tag(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) board.take_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        board.check_record(res_t'{
          is_summary:    out_ch.is_summary,
          option_code:   out_ch.option_code,
          option_length: out_ch.option_length,
          option_class:  out_ch.option_class,
          keytag_hits:   out_ch.keytag_hits,
          subnet_family: out_ch.subnet_family,
          subnet_prefix: out_ch.subnet_prefix,
          seen_mask:     out_ch.seen_mask,
          udp_size:      out_ch.udp_size,
          do_flag:       out_ch.do_flag,
          edns_version:  out_ch.edns_version,
          status:        out_ch.status
        });
      end
    end
  end

  // receiver: rotating stall patterns plus an on-demand long hold
  initial begin : receiver
    int cyc;
    int hold_left;
    cyc = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = 80;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        case ((cyc / 150) % 4)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = 1'($urandom_range(0, 1));
          2: out_ch.ready = (cyc % 4 == 0);
          default: out_ch.ready = ($urandom_range(0, 9) != 0);
        endcase
      end
      cyc++;
    end
  end

  initial begin : timeout_guard
    #2_000_000;
    $display("dns_edns_option_parser test failed");
    $finish;
  end

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
  endtask

  task automatic put_byte(logic [7:0] b, logic l);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data_byte = b;
    in_ch.last_byte = l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) put_byte(pkt[i], i == pkt.size() - 1);
    pkt.delete();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_tag(cfg_idx_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    tags_now[idx] = v;
  endtask

  task automatic push_word(logic [15:0] w);
    pkt.push_back(w[15:8]);
    pkt.push_back(w[7:0]);
  endtask

  task automatic push_header(logic [15:0] udp, logic [7:0] ver, logic [15:0] flags,
                             logic [15:0] rdlen);
    pkt.push_back(8'd0);
    pkt.push_back(8'd0);
    pkt.push_back(OPT_TYPE);
    push_word(udp);
    pkt.push_back(8'($urandom));
    pkt.push_back(ver);
    push_word(flags);
    push_word(rdlen);
  endtask

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return 16'($urandom_range(0, 15));
      4, 5, 6: return CODE_SUBNET;
      7, 8, 9: return CODE_KEYTAG;
      10: return CODE_EXP_KNW;
      11: return CODE_FUTURE;
      12: return 16'($urandom_range(65002, 65534));
      13: return 16'($urandom_range(64990, 65010));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_option();
    logic [15:0] c;
    logic [15:0] len;
    logic [15:0] t;
    int          i;
    c = pick_code();
    if (c == CODE_SUBNET) len = 16'($urandom_range(0, 10));
    else if (c == CODE_KEYTAG) len = 16'($urandom_range(0, 9));
    else len = 16'($urandom_range(0, 6));
    opt_body.push_back(c[15:8]);
    opt_body.push_back(c[7:0]);
    opt_body.push_back(len[15:8]);
    opt_body.push_back(len[7:0]);
    i = 0;
    while (i < len) begin
      if (c == CODE_KEYTAG && i + 1 < len) begin
        case ($urandom_range(0, 4))
          0: t = tags_now[0];
          1: t = tags_now[1];
          2: t = tags_now[2];
          default: t = 16'($urandom);
        endcase
        opt_body.push_back(t[15:8]);
        opt_body.push_back(t[7:0]);
        i += 2;
      end else begin
        opt_body.push_back(8'($urandom));
        i++;
      end
    end
  endtask

  task automatic make_packet();
    int          kind;
    int          d;
    int          cut;
    logic [15:0] rdlen;
    opt_body.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 92 && kind < 96) begin
      repeat ($urandom_range(1, 16)) pkt.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 4)) add_option();
    if (kind >= 96) begin
      rdlen = pick_code();
      opt_body.push_back(rdlen[15:8]);
      opt_body.push_back(rdlen[7:0]);
      rdlen = 16'($urandom_range(7, 65535));
      opt_body.push_back(rdlen[15:8]);
      opt_body.push_back(rdlen[7:0]);
      repeat ($urandom_range(0, 6)) opt_body.push_back(8'($urandom));
    end
    rdlen = 16'(opt_body.size());
    if (kind >= 70 && kind < 78) begin
      if ($urandom_range(0, 3) == 0) begin
        rdlen = 16'($urandom);
      end else begin
        d = opt_body.size() + $urandom_range(0, 6) - 3;
        rdlen = (d < 0) ? 16'd0 : 16'(d);
      end
    end
    push_header(16'($urandom), 8'($urandom), 16'($urandom), rdlen);
    foreach (opt_body[i]) pkt.push_back(opt_body[i]);
    if (kind >= 78 && kind < 86) repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
    if (kind >= 86 && kind < 92) begin
      cut = $urandom_range(0, 2);
      pkt[cut] = pkt[cut] ^ 8'($urandom_range(1, 255));
    end
    if ((kind >= 60 && kind < 70) || (kind >= 86 && kind < 92)) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  initial begin : stimulus
    int phase_end;
    int pkt_count;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_TAG_A;
    cfg_ch.data = '0;
    hold_request = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    pkt_count = 0;
    tags_now[0] = TAG_A_RST;
    tags_now[1] = TAG_B_RST;
    tags_now[2] = TAG_C_RST;
    board = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // bad first byte, packet ends in header
    pkt.push_back(8'h01);
    send_packet();
    // wrong type, rest ignored
    pkt = '{8'h00, 8'h00, 8'd40, 8'hff, 8'hff};
    send_packet();
    // header only, extremes
    push_header(16'hffff, 8'hff, 16'h8000, 16'd0);
    send_packet();
    // subnet, keytag with odd byte, then a code 65535 that ends the packet
    push_header(16'd0, 8'd0, 16'h7fff, 16'd23);
    push_word(CODE_SUBNET); push_word(16'd4); push_word(16'h0001);
    pkt.push_back(8'd24); pkt.push_back(8'd0);
    push_word(CODE_KEYTAG); push_word(16'd7);
    push_word(TAG_A_RST); push_word(TAG_B_RST); push_word(TAG_C_RST);
    pkt.push_back(8'h55);
    push_word(CODE_FUTURE); push_word(16'd0);
    send_packet();
    // short subnet, option overruns rdata
    push_header(16'd1232, 8'd1, 16'd0, 16'd13);
    push_word(CODE_SUBNET); push_word(16'd1); pkt.push_back(8'hab);
    push_word(CODE_EXP_KNW); push_word(16'd6);
    pkt.push_back(8'hde); pkt.push_back(8'had); pkt.push_back(8'hbe); pkt.push_back(8'hef);
    send_packet();
    // rdata ends inside option length field
    push_header(16'd512, 8'd0, 16'd0, 16'd3);
    push_word(CODE_UNASSGN); pkt.push_back(8'd0);
    send_packet();
    // packet ends inside body before rdata is done
    push_header(16'd4096, 8'd0, 16'h8000, 16'd100);
    push_word(16'd4); push_word(16'd0);
    push_word(16'd65002); push_word(16'd3); pkt.push_back(8'h77);
    send_packet();
    // packet ends inside option length field
    push_header(16'd4096, 8'd0, 16'd0, 16'd50);
    push_word(16'd5); pkt.push_back(8'd0);
    send_packet();
    // known, unassigned and experimental codes with zero length, trailing byte
    push_header(16'd1400, 8'd0, 16'd0, 16'd12);
    push_word(16'd0); push_word(16'd0);
    push_word(16'd15); push_word(16'd0);
    push_word(16'd65534); push_word(16'd0);
    pkt.push_back(8'hff);
    send_packet();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: begin
            write_tag(CFG_TAG_A, 16'h0000);
            write_tag(CFG_TAG_B, 16'h0000);
            write_tag(CFG_TAG_C, 16'h0000);
          end
          2: begin
            write_tag(CFG_TAG_A, 16'hffff);
            write_tag(CFG_TAG_B, 16'hffff);
            write_tag(CFG_TAG_C, 16'hffff);
          end
          3: begin
            write_tag(CFG_TAG_A, 16'($urandom));
            write_tag(CFG_TAG_B, 16'($urandom));
            write_tag(CFG_TAG_C, 16'($urandom));
          end
          4: begin
            write_tag(CFG_TAG_C, 16'h8000);
            write_tag(CFG_TAG_B, 16'hffff);
            write_tag(CFG_TAG_A, 16'h0000);
          end
          default: begin
            write_tag(CFG_TAG_A, TAG_A_RST);
            write_tag(CFG_TAG_B, TAG_B_RST);
            write_tag(CFG_TAG_C, TAG_C_RST);
          end
        endcase
      end
      if (ph == 2) hold_request = 1'b1;
      phase_end = bytes_sent + 215;
      while (bytes_sent < phase_end) begin
        make_packet();
        send_packet();
        pkt_count++;
        if (pkt_count % 37 == 0) wait_idle();
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.due.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.due.size() == 0) begin
      $display("dns_edns_option_parser test passed");
    end else begin
      $display("dns_edns_option_parser test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/edns_pkg.sv
rtl/edns_in_if.sv
rtl/edns_out_if.sv
rtl/edns_cfg_if.sv
rtl/edns_parse.sv
rtl/edns_outq.sv
rtl/dns_edns_option_parser.sv
verif/dns_edns_option_parser_test.sv
